>>> rtl/core/ltsg_pkg.sv
// ----------------------------------------------------------------------------
// ltsg_pkg
// Shared types and constants for the layout transfer segment generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ltsg_pkg;

   localparam int OFFSET_BITS = 40;
   localparam int LIST_DEPTH  = 64;
   localparam int LIST_AW     = $clog2(LIST_DEPTH);
   localparam int CNT_W       = LIST_AW + 1;
   localparam int ELEM_W      = 24;
   localparam int EB_W        = 9;
   localparam int BYTES_W     = 32;
   localparam int CSR_IDX_W   = 3;

   // layout modes
   localparam logic [1:0] MODE_CONTIG  = 2'd0;
   localparam logic [1:0] MODE_STRIDED = 2'd1;
   localparam logic [1:0] MODE_LIST    = 2'd2;

   // item kinds
   localparam logic [1:0] KIND_CLEAR   = 2'd0;
   localparam logic [1:0] KIND_SRC_ADD = 2'd1;
   localparam logic [1:0] KIND_DST_ADD = 2'd2;
   localparam logic [1:0] KIND_NEXT    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_MODE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEM_BYTES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_RUN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_STRIDE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_RUN    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_STRIDE = 3'd7;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ELEM_W-1:0] entry_offset;
      logic [ELEM_W-1:0] entry_length;
   } req_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] seg_src_offset;
      logic [OFFSET_BITS-1:0] seg_dst_offset;
      logic [BYTES_W-1:0]     seg_bytes;
      logic                   seg_last;
      logic                   seg_error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BASE,
      ST_CURSOR,
      ST_PICK,
      ST_ISSUE,
      ST_ERROR
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic check;
      logic base;
      logic cursor;
      logic pick;
      logic issue;
      logic error;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_next;
      logic finished;
      logic bad;
      logic out_busy;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/core/layout_transfer_segment_generator.sv
// ----------------------------------------------------------------------------
// layout_transfer_segment_generator
// Builds copy segments that move a run of elements between two layouts.
// ----------------------------------------------------------------------------
// Clear, append-source and append-destination items are taken and handled
// in the idle state. A next-segment item is taken in the idle state and then
// runs five steps (list read and checks, block base with stride multiply,
// element-size scaling, min pick, byte count and issue); the chain of
// dependent multiplies sets that length. The segment is written to the output
// register in the issue step, and an error result in the error step that
// follows the checks; a step on a finished transfer gives no result and
// returns to idle after the checks. One item is
// in work at a time; a finished result sits in an output register and the
// block goes back to accepting while it waits; the issue and error steps
// stall only while that register still holds an unaccepted result.
// Registers must be written through the csr port only while no item is in
// work; the block does not enforce this. The csr port is always ready.
`default_nettype none

module layout_transfer_segment_generator (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  ltsg_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output ltsg_pkg::rsp_type                rsp_payload,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [ltsg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [ltsg_pkg::ELEM_W-1:0]      csr_data
);

   ltsg_pkg::cmd_type cmd;
   ltsg_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer
   ltsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   ltsg_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire

>>> rtl/core/ltsg_ctrl.sv
// ----------------------------------------------------------------------------
// ltsg_ctrl
// Sequencer that steps the datapath through one segment computation.
// ----------------------------------------------------------------------------
`default_nettype none

module ltsg_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  ltsg_pkg::sts_type   sts,
   output ltsg_pkg::cmd_type   cmd
);

   ltsg_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ltsg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ltsg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.is_next) state_in = ltsg_pkg::ST_CHECK;
            end
         end
         ltsg_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            if (sts.finished)  state_in = ltsg_pkg::ST_IDLE;
            else if (sts.bad)  state_in = ltsg_pkg::ST_ERROR;
            else               state_in = ltsg_pkg::ST_BASE;
         end
         ltsg_pkg::ST_BASE: begin
            cmd.base = 1'b1;
            state_in = ltsg_pkg::ST_CURSOR;
         end
         ltsg_pkg::ST_CURSOR: begin
            cmd.cursor = 1'b1;
            state_in   = ltsg_pkg::ST_PICK;
         end
         ltsg_pkg::ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ltsg_pkg::ST_ISSUE;
         end
         ltsg_pkg::ST_ISSUE: begin
            if (!sts.out_busy) begin
               cmd.issue = 1'b1;
               state_in  = ltsg_pkg::ST_IDLE;
            end
         end
         ltsg_pkg::ST_ERROR: begin
            if (!sts.out_busy) begin
               cmd.error = 1'b1;
               state_in  = ltsg_pkg::ST_IDLE;
            end
         end
         default: state_in = ltsg_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/ltsg_dp.sv
// ----------------------------------------------------------------------------
// ltsg_dp
// Registers, block lists, merge arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ltsg_dp (
   input  wire                                      clock,
   input  wire                                      reset,
   input  ltsg_pkg::req_type                        req_payload,
   output ltsg_pkg::rsp_type                        rsp_payload,
   output logic                                     rsp_valid,
   input  wire                                      rsp_ready,
   input  wire                                      csr_valid,
   input  wire  [ltsg_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire  [ltsg_pkg::ELEM_W-1:0]              csr_data,
   input  ltsg_pkg::cmd_type                        cmd,
   output ltsg_pkg::sts_type                        sts
);

   localparam int OB  = ltsg_pkg::OFFSET_BITS;
   localparam int EW  = ltsg_pkg::ELEM_W;
   localparam int CW  = ltsg_pkg::CNT_W;
   localparam int AW  = ltsg_pkg::LIST_AW;
   localparam int EBW = ltsg_pkg::EB_W;

   // configuration
   logic [1:0]     src_mode_ff, dst_mode_ff;
   logic [EBW-1:0] elem_bytes_ff;
   logic [EW-1:0]  total_ff, src_run_ff, src_stride_ff, dst_run_ff, dst_stride_ff;

   // transfer state
   logic [CW-1:0]  src_cnt_ff, dst_cnt_ff;
   logic [EW-1:0]  src_idx_ff, dst_idx_ff;
   logic [EW-1:0]  src_rem_ff, dst_rem_ff;
   logic           src_ld_ff, dst_ld_ff;
   logic [OB-1:0]  src_cur_ff, dst_cur_ff;
   logic [EW-1:0]  done_ff;

   // working registers
   logic [2*EW-1:0] src_ent_ff, dst_ent_ff;
   logic [OB-1:0]   src_base_ff, dst_base_ff;
   logic [EW-1:0]   rs_ff, rd_ff;
   logic [OB-1:0]   cs_ff, cd_ff;
   logic [EW-1:0]   m_ff;

   // result register
   ltsg_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;

   // block lists: offset in upper half, length in lower half
   logic [2*EW-1:0] src_mem [ltsg_pkg::LIST_DEPTH];
   logic [2*EW-1:0] dst_mem [ltsg_pkg::LIST_DEPTH];

   logic           src_add, dst_add, clr;
   logic           src_bad, dst_bad;
   logic [2*EW-1:0] src_stp, dst_stp;
   logic [OB+EBW-1:0] src_scl, dst_scl;
   logic [EW-1:0]  left, m_in;
   logic [EW+EBW-1:0] nbytes;
   logic [EW-1:0]  rs_left, rd_left, done_next;

   assign clr     = cmd.accept && (req_payload.kind == ltsg_pkg::KIND_CLEAR);
   assign src_add = cmd.accept && (req_payload.kind == ltsg_pkg::KIND_SRC_ADD) &&
                    (src_cnt_ff < CW'(ltsg_pkg::LIST_DEPTH));
   assign dst_add = cmd.accept && (req_payload.kind == ltsg_pkg::KIND_DST_ADD) &&
                    (dst_cnt_ff < CW'(ltsg_pkg::LIST_DEPTH));

   // layout checks and list exhaustion
   always_comb begin
      src_bad = (src_mode_ff > ltsg_pkg::MODE_LIST) ||
                ((src_mode_ff == ltsg_pkg::MODE_STRIDED) && (src_run_ff == '0)) ||
                ((src_mode_ff == ltsg_pkg::MODE_LIST) && !src_ld_ff &&
                 (src_idx_ff >= EW'(src_cnt_ff)));
      dst_bad = (dst_mode_ff > ltsg_pkg::MODE_LIST) ||
                ((dst_mode_ff == ltsg_pkg::MODE_STRIDED) && (dst_run_ff == '0)) ||
                ((dst_mode_ff == ltsg_pkg::MODE_LIST) && !dst_ld_ff &&
                 (dst_idx_ff >= EW'(dst_cnt_ff)));
   end

   assign left         = total_ff - done_ff;
   assign sts.is_next  = (req_payload.kind == ltsg_pkg::KIND_NEXT);
   assign sts.finished = (done_ff >= total_ff);
   assign sts.bad      = src_bad || dst_bad;
   assign sts.out_busy = rsp_valid_ff && !rsp_ready;

   // arithmetic
   assign src_stp   = (2*EW)'(src_idx_ff) * (2*EW)'(src_stride_ff);
   assign dst_stp   = (2*EW)'(dst_idx_ff) * (2*EW)'(dst_stride_ff);
   assign src_scl   = (OB+EBW)'(src_base_ff) * (OB+EBW)'(elem_bytes_ff);
   assign dst_scl   = (OB+EBW)'(dst_base_ff) * (OB+EBW)'(elem_bytes_ff);
   assign nbytes    = (EW+EBW)'(m_ff) * (EW+EBW)'(elem_bytes_ff);
   assign rs_left   = rs_ff - m_ff;
   assign rd_left   = rd_ff - m_ff;
   assign done_next = done_ff + m_ff;

   always_comb begin
      m_in = left;
      if (rs_ff < m_in) m_in = rs_ff;
      if (rd_ff < m_in) m_in = rd_ff;
   end

   // list storage
   always_ff @(posedge clock) begin
      if (src_add) src_mem[src_cnt_ff[AW-1:0]] <= {req_payload.entry_offset,
                                                   req_payload.entry_length};
      if (dst_add) dst_mem[dst_cnt_ff[AW-1:0]] <= {req_payload.entry_offset,
                                                   req_payload.entry_length};
      if (cmd.check) begin
         src_ent_ff <= src_mem[src_idx_ff[AW-1:0]];
         dst_ent_ff <= dst_mem[dst_idx_ff[AW-1:0]];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_mode_ff   <= ltsg_pkg::MODE_CONTIG;
         dst_mode_ff   <= ltsg_pkg::MODE_CONTIG;
         elem_bytes_ff <= EBW'(1);
         total_ff      <= EW'(1);
         src_run_ff    <= EW'(1);
         src_stride_ff <= '0;
         dst_run_ff    <= EW'(1);
         dst_stride_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            ltsg_pkg::CSR_SRC_MODE:   src_mode_ff   <= csr_data[1:0];
            ltsg_pkg::CSR_DST_MODE:   dst_mode_ff   <= csr_data[1:0];
            ltsg_pkg::CSR_ELEM_BYTES: elem_bytes_ff <= csr_data[EBW-1:0];
            ltsg_pkg::CSR_TOTAL:      total_ff      <= csr_data;
            ltsg_pkg::CSR_SRC_RUN:    src_run_ff    <= csr_data;
            ltsg_pkg::CSR_SRC_STRIDE: src_stride_ff <= csr_data;
            ltsg_pkg::CSR_DST_RUN:    dst_run_ff    <= csr_data;
            ltsg_pkg::CSR_DST_STRIDE: dst_stride_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // block base offsets and rests, a side that is mid-block keeps its rest
   always_ff @(posedge clock) begin
      if (cmd.base) begin
         case (src_mode_ff)
            ltsg_pkg::MODE_CONTIG: begin
               src_base_ff <= OB'(done_ff);
               rs_ff       <= src_ld_ff ? src_rem_ff : left;
            end
            ltsg_pkg::MODE_STRIDED: begin
               src_base_ff <= src_stp[OB-1:0];
               rs_ff       <= src_ld_ff ? src_rem_ff : src_run_ff;
            end
            default: begin
               src_base_ff <= OB'(src_ent_ff[2*EW-1:EW]);
               rs_ff       <= src_ld_ff ? src_rem_ff : src_ent_ff[EW-1:0];
            end
         endcase
         case (dst_mode_ff)
            ltsg_pkg::MODE_CONTIG: begin
               dst_base_ff <= OB'(done_ff);
               rd_ff       <= dst_ld_ff ? dst_rem_ff : left;
            end
            ltsg_pkg::MODE_STRIDED: begin
               dst_base_ff <= dst_stp[OB-1:0];
               rd_ff       <= dst_ld_ff ? dst_rem_ff : dst_run_ff;
            end
            default: begin
               dst_base_ff <= OB'(dst_ent_ff[2*EW-1:EW]);
               rd_ff       <= dst_ld_ff ? dst_rem_ff : dst_ent_ff[EW-1:0];
            end
         endcase
      end
      if (cmd.cursor) begin
         cs_ff <= src_ld_ff ? src_cur_ff : src_scl[OB-1:0];
         cd_ff <= dst_ld_ff ? dst_cur_ff : dst_scl[OB-1:0];
      end
      if (cmd.pick) m_ff <= m_in;
   end

   // merge state
   always_ff @(posedge clock) begin
      if (reset) begin
         src_cnt_ff <= '0;
         dst_cnt_ff <= '0;
         src_idx_ff <= '0;
         dst_idx_ff <= '0;
         src_rem_ff <= '0;
         dst_rem_ff <= '0;
         src_ld_ff  <= 1'b0;
         dst_ld_ff  <= 1'b0;
         src_cur_ff <= '0;
         dst_cur_ff <= '0;
         done_ff    <= '0;
      end else if (clr) begin
         src_cnt_ff <= '0;
         dst_cnt_ff <= '0;
         src_idx_ff <= '0;
         dst_idx_ff <= '0;
         src_rem_ff <= '0;
         dst_rem_ff <= '0;
         src_ld_ff  <= 1'b0;
         dst_ld_ff  <= 1'b0;
         src_cur_ff <= '0;
         dst_cur_ff <= '0;
         done_ff    <= '0;
      end else begin
         if (src_add) src_cnt_ff <= src_cnt_ff + CW'(1);
         if (dst_add) dst_cnt_ff <= dst_cnt_ff + CW'(1);
         if (cmd.issue) begin
            done_ff    <= done_next;
            src_rem_ff <= rs_left;
            dst_rem_ff <= rd_left;
            if (rs_left == '0) begin
               src_idx_ff <= src_idx_ff + EW'(1);
               src_ld_ff  <= 1'b0;
               src_cur_ff <= cs_ff;
            end else begin
               src_ld_ff  <= 1'b1;
               src_cur_ff <= cs_ff + OB'(nbytes);
            end
            if (rd_left == '0) begin
               dst_idx_ff <= dst_idx_ff + EW'(1);
               dst_ld_ff  <= 1'b0;
               dst_cur_ff <= cd_ff;
            end else begin
               dst_ld_ff  <= 1'b1;
               dst_cur_ff <= cd_ff + OB'(nbytes);
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.issue || cmd.error) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rsp_ff.seg_src_offset <= cs_ff;
         rsp_ff.seg_dst_offset <= cd_ff;
         rsp_ff.seg_bytes      <= nbytes[ltsg_pkg::BYTES_W-1:0];
         rsp_ff.seg_last       <= (done_next >= total_ff);
         rsp_ff.seg_error      <= 1'b0;
      end else if (cmd.error) begin
         rsp_ff.seg_src_offset <= '0;
         rsp_ff.seg_dst_offset <= '0;
         rsp_ff.seg_bytes      <= '0;
         rsp_ff.seg_last       <= 1'b0;
         rsp_ff.seg_error      <= 1'b1;
      end
   end

   assign rsp_payload = rsp_ff;
   assign rsp_valid   = rsp_valid_ff;

endmodule

`default_nettype wire
